[hdl/lsmd_pkg.sv]
// Shared types, codes and reset values for the lidar sector minimum-distance unit.
// No dependencies; compiled first.
package lsmd_pkg;

    localparam int unsigned ANGLE_W = 15;
    localparam int unsigned DIST_W  = 16;
    localparam int unsigned LIMIT_W = 8;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // one full turn in 1/64 degree
    localparam logic [ANGLE_W-1:0] TURN_UNITS = 15'd23040;

    localparam logic [ANGLE_W-1:0] RST_SECTOR_LOW  = 15'd21600;
    localparam logic [ANGLE_W-1:0] RST_SECTOR_HIGH = 15'd1440;
    localparam logic [DIST_W-1:0]  RST_RANGE_MIN   = 16'd50;
    localparam logic [DIST_W-1:0]  RST_RANGE_MAX   = 16'd14000;
    localparam logic [DIST_W-1:0]  RST_TIMEOUT     = 16'd1000;
    localparam logic [DIST_W-1:0]  RST_BACKOFF     = 16'd500;
    localparam logic [LIMIT_W-1:0] RST_ERR_LIMIT   = 8'd20;

    typedef enum logic [1:0] {
        FUNC_POINT = 2'd0,
        FUNC_ERROR = 2'd1,
        FUNC_TICK  = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        KIND_UPDATE  = 2'd0,
        KIND_INVALID = 2'd1,
        KIND_RESTART = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SECTOR_LOW  = 3'd0,
        CFG_SECTOR_HIGH = 3'd1,
        CFG_RANGE_MIN   = 3'd2,
        CFG_RANGE_MAX   = 3'd3,
        CFG_TIMEOUT     = 3'd4,
        CFG_BACKOFF     = 3'd5,
        CFG_ERR_LIMIT   = 3'd6
    } t_cfg_idx;

    // acceptance window handed to the point check
    typedef struct packed {
        logic [ANGLE_W-1:0] sector_low;
        logic [ANGLE_W-1:0] sector_high;
        logic [DIST_W-1:0]  range_min;
        logic [DIST_W-1:0]  range_max;
    } t_window;

    // fold an angle at or past one turn back into range
    function automatic logic [ANGLE_W-1:0] wrap_turn(input logic [ANGLE_W-1:0] a);
        logic [ANGLE_W-1:0] r;
        r = (a >= TURN_UNITS) ? a - TURN_UNITS : a;
        return r;
    endfunction

endpackage

[hdl/lsmd_if.sv]
// Valid/ready channel interfaces for lidar items in and reports out.
// Depends on nothing; widths match lsmd_pkg.
interface lsmd_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [14:0] angle;
    logic [15:0] distance;
    logic        scan_start;

    modport source (output valid, func, angle, distance, scan_start, input ready);
    modport sink   (input valid, func, angle, distance, scan_start, output ready);
endinterface

interface lsmd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  report_kind;
    logic [15:0] nearest;

    modport source (output valid, report_kind, nearest, input ready);
    modport sink   (input valid, report_kind, nearest, output ready);
endinterface

[hdl/lsmd_point_check.sv]
// Sector and range test for one lidar point.
// Depends on lsmd_pkg (t_window, wrap_turn).
module lsmd_point_check import lsmd_pkg::*; (
    input  t_window             i_win,
    input  logic [ANGLE_W-1:0]  i_angle,
    input  logic [DIST_W-1:0]   i_distance,
    output logic                o_hit
);

    logic [ANGLE_W-1:0] lo;
    logic [ANGLE_W-1:0] hi;
    logic [ANGLE_W-1:0] ang;
    logic               in_sector;
    logic               in_range;

    always_comb begin
        lo  = wrap_turn(i_win.sector_low);
        hi  = wrap_turn(i_win.sector_high);
        ang = wrap_turn(i_angle);
        // low above high means the sector runs through zero
        if (lo <= hi) begin
            in_sector = (ang >= lo) && (ang <= hi);
        end else begin
            in_sector = (ang >= lo) || (ang <= hi);
        end
        in_range = (i_distance >= i_win.range_min) && (i_distance <= i_win.range_max);
        o_hit    = in_sector && in_range;
    end

endmodule

[hdl/lidar_sector_min_distance_unit.sv]
// Top level: lidar sector minimum-distance tracker with config registers.
// Depends on lsmd_pkg, lsmd_if and lsmd_point_check.
//
//  channel   dir  handshake          payload
//  i_pt      in   valid/ready        func, angle, distance, scan_start
//  o_rep     out  valid/ready        report_kind, nearest
//  cfg       in   i_cfg_we           i_cfg_idx, i_cfg_data
//
// One item per cycle while the report channel is not stalled; a taken item passes through the input register,
// then one pass of compare/update logic, into the result register.
// Synchronous active-low reset restores register defaults and clears the tracker.
// A stalled result holds the result register; the input register keeps taking items
// until it too is full, so at most two items sit inside.
module lidar_sector_min_distance_unit import lsmd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    lsmd_in_if.sink               i_pt,
    lsmd_out_if.source            o_rep,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // config registers
    logic [ANGLE_W-1:0] r_sector_low;
    logic [ANGLE_W-1:0] r_sector_high;
    logic [DIST_W-1:0]  r_range_min;
    logic [DIST_W-1:0]  r_range_max;
    logic [DIST_W-1:0]  r_timeout;
    logic [DIST_W-1:0]  r_backoff;
    logic [LIMIT_W-1:0] r_err_limit;

    // input register
    logic               r_in_valid;
    logic [1:0]         r_func;
    logic [ANGLE_W-1:0] r_angle;
    logic [DIST_W-1:0]  r_distance;
    logic               r_scan_start;

    // tracker state
    logic [DIST_W-1:0]  r_min;
    logic               r_found;
    logic [LIMIT_W-1:0] r_err_run;
    logic [DIST_W-1:0]  r_idle;

    // result register
    logic               r_out_valid;
    t_kind              r_kind;
    logic [DIST_W-1:0]  r_nearest;

    // next values
    logic [DIST_W-1:0]  n_min;
    logic               n_found;
    logic [LIMIT_W-1:0] n_err_run;
    logic [DIST_W-1:0]  n_idle;
    logic               n_res;
    t_kind              n_kind;
    logic [DIST_W-1:0]  n_nearest;

    logic               fire;
    logic               in_ready;
    logic               hit;
    logic               found_kept;
    logic [LIMIT_W-1:0] limit;
    logic [LIMIT_W-1:0] run_inc;
    logic [DIST_W-1:0]  idle_inc;
    t_window            win;

    assign fire     = r_in_valid && (!r_out_valid || o_rep.ready);
    assign in_ready = !r_in_valid || fire;

    assign i_pt.ready        = in_ready;
    assign o_rep.valid       = r_out_valid;
    assign o_rep.report_kind = r_kind;
    assign o_rep.nearest     = r_nearest;

    assign win = '{sector_low:  r_sector_low,
                   sector_high: r_sector_high,
                   range_min:   r_range_min,
                   range_max:   r_range_max};

    lsmd_point_check u_check (
        .i_win      (win),
        .i_angle    (r_angle),
        .i_distance (r_distance),
        .o_hit      (hit)
    );

    always_comb begin
        n_min     = r_min;
        n_found   = r_found;
        n_err_run = r_err_run;
        n_idle    = r_idle;
        n_res     = 1'b0;
        n_kind    = KIND_UPDATE;
        n_nearest = '0;
        found_kept = r_found && !r_scan_start;
        limit     = (r_err_limit == '0) ? LIMIT_W'(1) : r_err_limit;
        run_inc   = (r_err_run == '1) ? r_err_run : r_err_run + LIMIT_W'(1);
        idle_inc  = (r_idle == '1) ? r_idle : r_idle + DIST_W'(1);
        unique case (r_func)
            FUNC_POINT: begin
                n_idle    = '0;
                n_err_run = '0;
                if (r_scan_start && r_found) begin
                    n_res     = 1'b1;
                    n_kind    = KIND_UPDATE;
                    n_nearest = r_min;
                end
                n_found = found_kept;
                if (hit && (!found_kept || r_distance < r_min)) begin
                    n_min   = r_distance;
                    n_found = 1'b1;
                end
            end
            FUNC_ERROR: begin
                n_err_run = run_inc;
                if (run_inc >= limit) begin
                    n_res     = 1'b1;
                    n_kind    = KIND_RESTART;
                    n_err_run = '0;
                    n_idle    = '0;
                    n_found   = 1'b0;
                end
            end
            FUNC_TICK: begin
                n_idle = idle_inc;
                if (idle_inc > r_timeout) begin
                    n_res  = 1'b1;
                    n_kind = KIND_INVALID;
                    n_idle = r_backoff;
                end
            end
            default: begin
                // unused code: no change, no report
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sector_low  <= RST_SECTOR_LOW;
            r_sector_high <= RST_SECTOR_HIGH;
            r_range_min   <= RST_RANGE_MIN;
            r_range_max   <= RST_RANGE_MAX;
            r_timeout     <= RST_TIMEOUT;
            r_backoff     <= RST_BACKOFF;
            r_err_limit   <= RST_ERR_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SECTOR_LOW:  r_sector_low  <= i_cfg_data[ANGLE_W-1:0];
                CFG_SECTOR_HIGH: r_sector_high <= i_cfg_data[ANGLE_W-1:0];
                CFG_RANGE_MIN:   r_range_min   <= i_cfg_data[DIST_W-1:0];
                CFG_RANGE_MAX:   r_range_max   <= i_cfg_data[DIST_W-1:0];
                CFG_TIMEOUT:     r_timeout     <= i_cfg_data[DIST_W-1:0];
                CFG_BACKOFF:     r_backoff     <= i_cfg_data[DIST_W-1:0];
                CFG_ERR_LIMIT:   r_err_limit   <= i_cfg_data[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_pt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_pt.valid) begin
            r_func       <= i_pt.func;
            r_angle      <= i_pt.angle;
            r_distance   <= i_pt.distance;
            r_scan_start <= i_pt.scan_start;
        end
    end

    // tracker state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found     <= 1'b0;
            r_err_run   <= '0;
            r_idle      <= '0;
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_found     <= n_found;
            r_err_run   <= n_err_run;
            r_idle      <= n_idle;
            r_out_valid <= n_res;
        end else if (o_rep.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_min <= n_min;
            if (n_res) begin
                r_kind    <= n_kind;
                r_nearest <= n_nearest;
            end
        end
    end

endmodule

[hdl/lsmd_checker.sv]
// Port-level checks for the lidar sector minimum-distance unit, bound to the top.
// Depends on lsmd_pkg (report codes) and the top level's ports.
module lsmd_checker import lsmd_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_kind,
    input logic [15:0] i_nearest
);

    // a waiting report is not withdrawn
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("report dropped while stalled");

    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_kind == KIND_UPDATE || i_kind == KIND_INVALID ||
                         i_kind == KIND_RESTART))
        else $error("undefined report kind");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_kind != KIND_UPDATE) |-> (i_nearest == 16'd0))
        else $error("nonzero distance on invalid/restart report");

    // nothing comes out the cycle after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("report valid after reset");

endmodule

bind lidar_sector_min_distance_unit lsmd_checker u_lsmd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_rep.valid),
    .i_out_ready (o_rep.ready),
    .i_kind      (o_rep.report_kind),
    .i_nearest   (o_rep.nearest)
);
